// ===== src/wendland_c2_rbf_weight_assert.svh =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF weight assertion macros
// Shared concurrent assertion forms for the weight pipeline.
// ----------------------------------------------------------------------------
`ifndef WENDLAND_C2_RBF_WEIGHT_ASSERT_SVH
`define WENDLAND_C2_RBF_WEIGHT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WC2RBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WC2RBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wc2rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF weight package
// Widths, register codes and shared types of the weight pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wc2rbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int DIFF_W    = 32;
    localparam int SQ_W      = 2 * RAD_W;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int WEIGHT_W  = 17;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam int DOWN_SHIFT = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int UP_SHIFT   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    localparam logic [RAD_W-1:0]    RADIUS_RESET = RAD_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = WEIGHT_W'(65536);

    typedef struct packed {
        logic vld;
        logic ins;
    } t_ctl;

endpackage

`default_nettype wire

// ===== src/wc2rbf_if.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF weight stream interfaces
// Point input channel and weight output channel with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wc2rbf_pt_if;
    logic                               valid;
    logic                               ready;
    logic [wc2rbf_pkg::COORD_W-1:0]     point_x;
    logic [wc2rbf_pkg::COORD_W-1:0]     point_y;
    logic [wc2rbf_pkg::COORD_W-1:0]     point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface wc2rbf_wt_if;
    logic                               valid;
    logic                               ready;
    logic [wc2rbf_pkg::WEIGHT_W-1:0]    weight;

    modport source (output valid, output weight, input ready);
    modport sink (input valid, input weight, output ready);
endinterface

`default_nettype wire

// ===== src/wc2rbf_dist.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF squared distance
// Absolute differences, squares, sum and support test over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wc2rbf_dist (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_vld,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_px,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_py,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_pz,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_cx,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_cy,
    input  wire logic [wc2rbf_pkg::COORD_W-1:0] i_cz,
    input  wire logic [wc2rbf_pkg::RAD_W-1:0]   i_rad,
    input  wire logic [wc2rbf_pkg::SQ_W-1:0]    i_rsq,
    output wc2rbf_pkg::t_ctl                    o_ctl,
    output logic [wc2rbf_pkg::SUM_W-1:0]        o_sum
);
    import wc2rbf_pkg::*;

    logic signed [DIFF_W:0] n_dx, n_dy, n_dz;
    logic [DIFF_W-1:0]      n_ax, n_ay, n_az;
    logic                   n_near;

    t_ctl              r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [DIFF_W-1:0] r_ax, r_ay, r_az;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [SUM_W-1:0]  r_sum3, r_sum4;

    always_comb begin
        n_dx = $signed({i_px[COORD_W-1], i_px}) - $signed({i_cx[COORD_W-1], i_cx});
        n_dy = $signed({i_py[COORD_W-1], i_py}) - $signed({i_cy[COORD_W-1], i_cy});
        n_dz = $signed({i_pz[COORD_W-1], i_pz}) - $signed({i_cz[COORD_W-1], i_cz});
        n_ax = n_dx[DIFF_W] ? DIFF_W'(-n_dx) : n_dx[DIFF_W-1:0];
        n_ay = n_dy[DIFF_W] ? DIFF_W'(-n_dy) : n_dy[DIFF_W-1:0];
        n_az = n_dz[DIFF_W] ? DIFF_W'(-n_dz) : n_dz[DIFF_W-1:0];
        n_near = (n_ax < DIFF_W'(i_rad)) && (n_ay < DIFF_W'(i_rad))
                 && (n_az < DIFF_W'(i_rad));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl1 <= '{vld: i_vld, ins: n_near};
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= '{vld: r_ctl3.vld, ins: r_ctl3.ins && (r_sum3 < SUM_W'(i_rsq))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_az   <= n_az;
            r_sx   <= r_ax[RAD_W-1:0] * r_ax[RAD_W-1:0];
            r_sy   <= r_ay[RAD_W-1:0] * r_ay[RAD_W-1:0];
            r_sz   <= r_az[RAD_W-1:0] * r_az[RAD_W-1:0];
            r_sum3 <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
            r_sum4 <= r_sum3;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_sum = r_sum4;

endmodule

`default_nettype wire

// ===== src/wc2rbf_sqrt.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF square root
// Digit-by-digit integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wc2rbf_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wc2rbf_pkg::t_ctl                    i_ctl,
    input  wire logic [wc2rbf_pkg::SUM_W-1:0]   i_sum,
    output wc2rbf_pkg::t_ctl                    o_ctl,
    output logic [wc2rbf_pkg::RAD_W-1:0]        o_dist
);
    import wc2rbf_pkg::*;

    t_ctl              r_ctl  [0:ROOT_W];
    logic [SUM_W-1:0]  r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];

    always_comb begin
        r_ctl[0]  = i_ctl;
        r_rem[0]  = i_sum;
        r_root[0] = '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  n_trial;
        logic              n_take;

        always_comb begin
            n_trial = (SUM_W'(r_root[k]) << (BIT + 1)) + (SUM_W'(1) << (2 * BIT));
            n_take  = r_rem[k] >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_take ? r_rem[k] - n_trial : r_rem[k];
                r_root[k+1] <= n_take ? (r_root[k] | (ROOT_W'(1) << BIT)) : r_root[k];
            end
        end
    end

    // Outside the support the distance is forced to zero so the divider stays in range.
    assign o_ctl  = r_ctl[ROOT_W];
    assign o_dist = r_ctl[ROOT_W].ins ? r_root[ROOT_W][RAD_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== src/wc2rbf_div.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF ratio divider
// Restoring division of the distance by the radius, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wc2rbf_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wc2rbf_pkg::t_ctl                    i_ctl,
    input  wire logic [wc2rbf_pkg::RAD_W-1:0]   i_dist,
    input  wire logic [wc2rbf_pkg::RAD_W-1:0]   i_rad,
    output wc2rbf_pkg::t_ctl                    o_ctl,
    output logic [wc2rbf_pkg::FRAC_BITS-1:0]    o_ratio
);
    import wc2rbf_pkg::*;

    t_ctl                 r_ctl [0:FRAC_BITS];
    logic [RAD_W-1:0]     r_rem [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [0:FRAC_BITS];

    always_comb begin
        r_ctl[0] = i_ctl;
        r_rem[0] = i_dist;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
        logic [RAD_W:0] n_shift;
        logic           n_ge;

        always_comb begin
            n_shift = {r_rem[k], 1'b0};
            n_ge    = n_shift >= {1'b0, i_rad};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? RAD_W'(n_shift - {1'b0, i_rad}) : n_shift[RAD_W-1:0];
                r_quo[k+1] <= {r_quo[k][FRAC_BITS-2:0], n_ge};
            end
        end
    end

    assign o_ctl   = r_ctl[FRAC_BITS];
    assign o_ratio = r_quo[FRAC_BITS];

endmodule

`default_nettype wire

// ===== src/wc2rbf_poly.sv =====
// ----------------------------------------------------------------------------
// Wendland C2 RBF polynomial
// Evaluates (1-r)^4 (1+4r) in three multiply stages and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wc2rbf_poly (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wc2rbf_pkg::t_ctl                    i_ctl,
    input  wire logic [wc2rbf_pkg::FRAC_BITS-1:0] i_ratio,
    output logic                                o_vld,
    output logic [wc2rbf_pkg::WEIGHT_W-1:0]     o_weight
);
    import wc2rbf_pkg::*;

    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;
    localparam int P_W    = FRAC_BITS + 3;
    localparam int PROD_W = ONE_W + P_W;

    logic [ONE_W-1:0]    n_s;
    logic [2*ONE_W-1:0]  n_s2_full, n_s4_full;
    logic [PROD_W-1:0]   n_w_full;
    logic [ONE_W-1:0]    n_w;
    logic [31:0]         n_scaled;

    t_ctl             r_ctl1, r_ctl2;
    logic             r_vld3;
    logic [ONE_W-1:0] r_s2, r_s4;
    logic [P_W-1:0]   r_p1, r_p2;
    logic [WEIGHT_W-1:0] r_weight;

    always_comb begin
        n_s       = ONE - ONE_W'(i_ratio);
        n_s2_full = n_s * n_s;
        n_s4_full = r_s2 * r_s2;
        n_w_full  = r_s4 * r_p2;
        n_w       = (n_w_full >> FRAC_BITS) > PROD_W'(ONE) ? ONE
                    : ONE_W'(n_w_full >> FRAC_BITS);
        if (!r_ctl2.ins) begin
            n_w = '0;
        end
        n_scaled  = (32'(n_w) >> DOWN_SHIFT) << UP_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_vld3 <= r_ctl2.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2     <= ONE_W'(n_s2_full >> FRAC_BITS);
            r_p1     <= P_W'(ONE) + (P_W'(i_ratio) << 2);
            r_s4     <= ONE_W'(n_s4_full >> FRAC_BITS);
            r_p2     <= r_p1;
            r_weight <= (n_scaled > 32'(WEIGHT_MAX)) ? WEIGHT_MAX : n_scaled[WEIGHT_W-1:0];
        end
    end

    assign o_vld    = r_vld3;
    assign o_weight = r_weight;

endmodule

`default_nettype wire

// ===== src/wendland_c2_rbf_weight.sv =====
// An accepted point beat passes the distance, square root, divider and polynomial stages to its weight beat.
// Throughput: one point per cycle; the pipeline takes a new beat every cycle unless the output stalls.
// The depth comes mostly from the 32-stage square root and the 16-stage ratio divider.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset is synchronous, active low; it clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Wendland C2 RBF weight
// Top level: APB register file, stream handshake and the weight pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wendland_c2_rbf_weight_assert.svh"

module wendland_c2_rbf_weight (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wc2rbf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wc2rbf_pkg::DATA_W-1:0]  pwdata,
    output logic [wc2rbf_pkg::DATA_W-1:0]       prdata,
    output logic                                pready,
    wc2rbf_pt_if.sink                           i_pt,
    wc2rbf_wt_if.source                         o_wt
);
    import wc2rbf_pkg::*;

    logic [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [RAD_W-1:0]   r_rad;
    logic [SQ_W-1:0]    r_rsq;
    logic               n_en;
    logic [1:0]         n_idx;

    t_ctl               dist_ctl, sqrt_ctl, div_ctl;
    logic [SUM_W-1:0]   dist_sum;
    logic [RAD_W-1:0]   sqrt_dist;
    logic [FRAC_BITS-1:0] div_ratio;
    logic               poly_vld;
    logic [WEIGHT_W-1:0] poly_weight;

    assign n_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADIUS_RESET;
        end else if (psel && penable && pwrite) begin
            case (n_idx)
                REG_CENTER_X: r_cx  <= pwdata;
                REG_CENTER_Y: r_cy  <= pwdata;
                REG_CENTER_Z: r_cz  <= pwdata;
                REG_RADIUS:   r_rad <= pwdata[RAD_W-1:0];
                default:      r_cx  <= r_cx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= r_rad * r_rad;
    end

    always_comb begin
        case (n_idx)
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_CENTER_Z: prdata = r_cz;
            REG_RADIUS:   prdata = DATA_W'(r_rad);
            default:      prdata = '0;
        endcase
    end

    assign n_en       = !poly_vld || o_wt.ready;
    assign i_pt.ready = n_en;

    wc2rbf_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (i_pt.valid),
        .i_px    (i_pt.point_x),
        .i_py    (i_pt.point_y),
        .i_pz    (i_pt.point_z),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_cz    (r_cz),
        .i_rad   (r_rad),
        .i_rsq   (r_rsq),
        .o_ctl   (dist_ctl),
        .o_sum   (dist_sum)
    );

    wc2rbf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (dist_ctl),
        .i_sum   (dist_sum),
        .o_ctl   (sqrt_ctl),
        .o_dist  (sqrt_dist)
    );

    wc2rbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (sqrt_ctl),
        .i_dist  (sqrt_dist),
        .i_rad   (r_rad),
        .o_ctl   (div_ctl),
        .o_ratio (div_ratio)
    );

    wc2rbf_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_ctl    (div_ctl),
        .i_ratio  (div_ratio),
        .o_vld    (poly_vld),
        .o_weight (poly_weight)
    );

    assign o_wt.valid  = poly_vld;
    assign o_wt.weight = poly_weight;

    `WC2RBF_ASSERT_NOW(a_weight_max, o_wt.valid, o_wt.weight <= WEIGHT_MAX, "weight above one")
    `WC2RBF_ASSERT_NOW(a_stall_ready, o_wt.valid && !o_wt.ready, !i_pt.ready, "ready during stall")
    `WC2RBF_ASSERT_NEXT(a_stall_hold, o_wt.valid && !o_wt.ready, o_wt.valid, "result lost in stall")

endmodule

`default_nettype wire
